// ===== sv/mpdp_pkg.sv =====
// Package for the multi-pin debounce unit: shared types and constants.
// No dependencies.
package mpdp_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned CNT_W = 4;
    localparam int unsigned APIN_W = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;
    localparam logic [CNT_W-1:0] FILTER_RESET = 4'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_PINS = 2'd0,
        REG_INVERT_MASK = 2'd1,
        REG_FILTER_COUNT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic step;
        logic clear_all;
        logic [CNT_W-1:0] filter_count;
    } lane_ctrl_t;

endpackage

// ===== sv/mpdp_lane.sv =====
// One debounce lane: the change counter of a single pin and its flip decision.
// Depends on mpdp_pkg.
module mpdp_lane
    import mpdp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  lane_ctrl_t ctrl,
    input  logic       active,
    input  logic       differ,
    output logic       flip
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_inc;

    always_comb begin
        cnt_next = cnt_reg;
        flip = 1'b0;
        cnt_inc = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 4'd1;
        if (ctrl.step) begin
            if (ctrl.clear_all) begin
                cnt_next = '0;
            end else if (active) begin
                if (!differ) begin
                    cnt_next = '0;
                end else if (cnt_inc >= ctrl.filter_count) begin
                    flip = 1'b1;
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== sv/mpdp_merge.sv =====
// Merge stage: combines the lane flips into the next stable state and
// forms the 32-bit result fields. Depends on mpdp_pkg.
module mpdp_merge
    import mpdp_pkg::*;
#(
    parameter int unsigned PINS = 32
) (
    input  logic [PINS-1:0]    stable,
    input  logic [PINS-1:0]    flips,
    input  lane_ctrl_t         ctrl,
    input  logic [FIELD_W-1:0] invert_mask,
    output logic [PINS-1:0]    stable_next,
    output logic [FIELD_W-1:0] stable_levels,
    output logic [FIELD_W-1:0] logical_levels
);

    localparam int unsigned OUT_PINS = (PINS < FIELD_W) ? PINS : FIELD_W;

    always_comb begin
        stable_next = stable;
        if (ctrl.step && !ctrl.clear_all) begin
            stable_next = stable ^ flips;
        end
        stable_levels = '0;
        for (int j = 0; j < OUT_PINS; j++) begin
            stable_levels[j] = stable_next[j];
        end
        logical_levels = stable_levels ^ invert_mask;
    end

endmodule

// ===== sv/multi_pin_debounce_with_polarity_unit.sv =====
// Multi-pin debounce unit with per-pin polarity: top level.
// Each result is registered on acceptance and shows the next cycle.
// Throughput: one item per cycle unless the output stalls; parallel lanes
// filter all pins. An output register decouples the sides, so a new item is
// taken while the last result is being read. Reset clears the stable state,
// counters and registers (filter count to five); no clearing pass is needed.
module multi_pin_debounce_with_polarity_unit
    import mpdp_pkg::*;
#(
    parameter int unsigned PINS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FIELD_W-1:0]   s_raw_levels,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FIELD_W-1:0]   m_stable_levels,
    output logic [FIELD_W-1:0]   m_logical_levels
);

    localparam int unsigned IN_PINS = (PINS < FIELD_W) ? PINS : FIELD_W;

    logic [APIN_W-1:0]  active_pins_reg;
    logic [FIELD_W-1:0] invert_mask_reg;
    logic [CNT_W-1:0]   filter_count_reg;
    logic [PINS-1:0]    stable_reg;
    logic [PINS-1:0]    stable_next;
    logic               m_valid_reg;
    logic [FIELD_W-1:0] m_stable_reg;
    logic [FIELD_W-1:0] m_logical_reg;

    logic [PINS-1:0]    sample;
    logic [PINS-1:0]    act;
    logic [PINS-1:0]    diff;
    logic [PINS-1:0]    flips;
    logic [FIELD_W-1:0] stable_levels;
    logic [FIELD_W-1:0] logical_levels;
    logic               accept;
    lane_ctrl_t         ctrl;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;

    always_comb begin
        sample = '0;
        for (int j = 0; j < IN_PINS; j++) begin
            sample[j] = s_raw_levels[j];
        end
        for (int j = 0; j < PINS; j++) begin
            act[j] = (7'(j) < {1'b0, active_pins_reg});
        end
        diff = (sample ^ stable_reg) & act;
        ctrl.step = accept && (active_pins_reg != '0);
        ctrl.clear_all = (diff == '0);
        ctrl.filter_count = filter_count_reg;
    end

    for (genvar g = 0; g < PINS; g++) begin : g_lane
        mpdp_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .active  (act[g]),
            .differ  (diff[g]),
            .flip    (flips[g])
        );
    end

    mpdp_merge #(
        .PINS (PINS)
    ) u_merge (
        .stable         (stable_reg),
        .flips          (flips),
        .ctrl           (ctrl),
        .invert_mask    (invert_mask_reg),
        .stable_next    (stable_next),
        .stable_levels  (stable_levels),
        .logical_levels (logical_levels)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_pins_reg <= '0;
            invert_mask_reg <= '0;
            filter_count_reg <= FILTER_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ACTIVE_PINS: active_pins_reg <= cfg_wdata[APIN_W-1:0];
                REG_INVERT_MASK: invert_mask_reg <= cfg_wdata;
                REG_FILTER_COUNT: filter_count_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                stable_reg <= stable_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_stable_reg <= stable_levels;
            m_logical_reg <= logical_levels;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_stable_levels = m_stable_reg;
    assign m_logical_levels = m_logical_reg;

endmodule

// ===== sv/mpdp_checker.sv =====
// Port-level checker for the multi-pin debounce unit, bound to the top level.
// Depends on mpdp_pkg and multi_pin_debounce_with_polarity_unit.
module mpdp_checker
    import mpdp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [FIELD_W-1:0] m_stable_levels,
    input logic [FIELD_W-1:0] m_logical_levels
);

    a_stall_only_when_full: assert property (
        @(posedge aclk) disable iff (!aresetn) !s_ready |-> m_valid
    ) else $error("Input stalled while the output register is empty.");

    a_item_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn) s_valid && s_ready |=> m_valid
    ) else $error("Accepted item produced no result.");

    a_result_held: assert property (
        @(posedge aclk) disable iff (!aresetn) m_valid && !m_ready |=> m_valid
    ) else $error("Result dropped before it was taken.");

    a_payload_held: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_stable_levels) && $stable(m_logical_levels)
    ) else $error("Result payload changed while stalled.");

endmodule

bind multi_pin_debounce_with_polarity_unit mpdp_checker u_mpdp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_stable_levels  (m_stable_levels),
    .m_logical_levels (m_logical_levels)
);

// ===== sim/multi_pin_debounce_with_polarity_unit_tb.sv =====
// Testbench for multi_pin_debounce_with_polarity_unit: directed and random samples.
// A local debounce predictor checks each result item; depends on mpdp_pkg and the unit.
module multi_pin_debounce_with_polarity_unit_tb;
    import mpdp_pkg::*;

    localparam int unsigned PINS = 32;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [FIELD_W-1:0] stable;
        logic [FIELD_W-1:0] logical;
    } levels_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [FIELD_W-1:0]   s_raw_levels;
    logic                 m_valid;
    logic                 m_ready;
    logic [FIELD_W-1:0]   m_stable_levels;
    logic [FIELD_W-1:0]   m_logical_levels;

    logic [APIN_W-1:0]  pred_active;
    logic [FIELD_W-1:0] pred_invert;
    logic [CNT_W-1:0]   pred_filter;
    logic [FIELD_W-1:0] pred_stable;
    logic [CNT_W-1:0]   pred_cnt [PINS];

    levels_t pending_levels [$];
    int unsigned error_count;
    bit idle_en;

    multi_pin_debounce_with_polarity_unit #(
        .PINS(PINS)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_raw_levels(s_raw_levels),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_stable_levels(m_stable_levels),
        .m_logical_levels(m_logical_levels)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic levels_t debounce_predict(input logic [FIELD_W-1:0] raw);
        levels_t res;
        int unsigned n;
        logic [FIELD_W-1:0] act;
        logic [FIELD_W-1:0] diff;
        logic [FIELD_W-1:0] nxt;
        logic [CNT_W-1:0] c;
        n = (pred_active > PINS) ? PINS : pred_active;
        act = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
        diff = raw ^ pred_stable;
        if (n != 0) begin
            if ((diff & act) == '0) begin
                for (int i = 0; i < PINS; i++) pred_cnt[i] = '0;
            end else begin
                nxt = pred_stable;
                for (int i = 0; i < n; i++) begin
                    if (!diff[i]) begin
                        pred_cnt[i] = '0;
                    end else begin
                        c = pred_cnt[i];
                        if (c < CNT_MAX) c = c + 1'b1;
                        if (c >= pred_filter) begin
                            nxt[i] = ~nxt[i];
                            c = '0;
                        end
                        pred_cnt[i] = c;
                    end
                end
                pred_stable = nxt;
            end
        end
        res.stable = pred_stable;
        res.logical = pred_stable ^ pred_invert;
        return res;
    endfunction

    // Result checker: compares every accepted result item with the oldest prediction.
    initial begin
        levels_t exp_lv;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_levels.size() == 0) begin
                    $error("unexpected result item: stable_levels %h", m_stable_levels);
                    error_count++;
                end else begin
                    exp_lv = pending_levels.pop_front();
                    if (m_stable_levels !== exp_lv.stable) begin
                        $error("stable_levels: expected %h, actual %h",
                               exp_lv.stable, m_stable_levels);
                        error_count++;
                    end
                    if (m_logical_levels !== exp_lv.logical) begin
                        $error("logical_levels: expected %h, actual %h",
                               exp_lv.logical, m_logical_levels);
                        error_count++;
                    end
                end
            end
        end
    end

    // Result side readiness with random stall bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [FIELD_W-1:0] raw);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_levels <= raw;
        do @(posedge aclk); while (!s_ready);
        pending_levels.push_back(debounce_predict(raw));
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [FIELD_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_ACTIVE_PINS: pred_active = data[APIN_W-1:0];
            REG_INVERT_MASK: pred_invert = data;
            REG_FILTER_COUNT: pred_filter = data[CNT_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [APIN_W-1:0] active, input logic [FIELD_W-1:0] inv,
                             input logic [CNT_W-1:0] filt);
        quiesce();
        cfg_write(REG_ACTIVE_PINS, {2'($urandom_range(0, 3)), 24'd0, active});
        cfg_write(REG_INVERT_MASK, inv);
        cfg_write(REG_FILTER_COUNT, {4'($urandom_range(0, 15)), 24'd0, filt});
    endtask

    task automatic test_reset_state();
        send_sample('1);
        send_sample('0);
    endtask

    task automatic test_all_pins_flip();
        configure(6'd32, 32'hA5A5_A5A5, 4'd5);
        repeat (4) send_sample('1);
        send_sample('0);
        repeat (5) send_sample('1);
    endtask

    task automatic test_filter_lowered();
        configure(6'd32, 32'hFFFF_FFFF, 4'd15);
        repeat (4) send_sample('0);
        quiesce();
        cfg_write(REG_FILTER_COUNT, 32'd2);
        send_sample('0);
    endtask

    task automatic test_clamp_and_partial();
        configure(6'd63, 32'h0000_0000, 4'd1);
        send_sample(32'h0F0F_0F0F);
        configure(6'd12, 32'h1234_5678, 4'd1);
        send_sample('1);
    endtask

    task automatic test_filter_zero();
        configure(6'd5, 32'h8000_0001, 4'd0);
        send_sample(32'h0000_0015);
        send_sample(32'hFFFF_FFE5);
    endtask

    task automatic test_random_phase(input logic [APIN_W-1:0] active,
                                     input logic [FIELD_W-1:0] inv,
                                     input logic [CNT_W-1:0] filt, input int count);
        int sent;
        int len;
        logic [FIELD_W-1:0] target;
        logic [FIELD_W-1:0] glitch;
        configure(active, inv, filt);
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_sample($urandom);
                sent++;
            end else begin
                target = $urandom;
                len = $urandom_range(1, 2 * pred_filter + 4);
                for (int k = 0; k < len && sent < count; k++) begin
                    glitch = ($urandom_range(0, 3) == 0) ? ($urandom & $urandom & $urandom) : '0;
                    send_sample(target ^ glitch);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_ACTIVE_PINS;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_raw_levels <= '0;
        error_count = 0;
        idle_en = 1'b0;
        pred_active = '0;
        pred_invert = '0;
        pred_filter = FILTER_RESET;
        pred_stable = '0;
        for (int i = 0; i < PINS; i++) pred_cnt[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_all_pins_flip();
        idle_en = 1'b1;
        test_filter_lowered();
        test_clamp_and_partial();
        test_filter_zero();

        test_random_phase(6'd32, $urandom, 4'd5, 120);
        test_random_phase(6'd20, $urandom, 4'd1, 80);
        test_random_phase(6'd63, 32'hFFFF_FFFF, 4'd15, 120);
        test_random_phase(6'd0, 32'h0000_0000, 4'd3, 30);
        test_random_phase(6'd1, $urandom, 4'd0, 40);
        idle_en = 1'b0;
        test_random_phase(6'd32, $urandom, 4'($urandom_range(1, 15)), 240);

        quiesce();
        repeat (5) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
